// ===== design/aet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_pkg
// shared types, token kinds, scan modes and character codes of the tokenizer
// ----------------------------------------------------------------------------
package aet_pkg;

    // default parameter values
    localparam int NAME_MAX_DEFAULT   = 31;
    localparam int VALUE_BITS_DEFAULT = 31;
    localparam int LINE_BITS_DEFAULT  = 16;

    // output field widths
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 31;
    localparam int CHARS_W = 64;
    localparam int LEN_W   = 5;
    localparam int LINE_W  = 16;
    localparam int NAME_SHOWN = 8;

    // token kinds
    localparam logic [KIND_W-1:0] TK_EOF   = 4'd0;
    localparam logic [KIND_W-1:0] TK_SEMI  = 4'd1;
    localparam logic [KIND_W-1:0] TK_PLUS  = 4'd2;
    localparam logic [KIND_W-1:0] TK_MINUS = 4'd3;
    localparam logic [KIND_W-1:0] TK_SLASH = 4'd4;
    localparam logic [KIND_W-1:0] TK_STAR  = 4'd5;
    localparam logic [KIND_W-1:0] TK_INT   = 4'd6;
    localparam logic [KIND_W-1:0] TK_NAME  = 4'd7;
    localparam logic [KIND_W-1:0] TK_ERR   = 4'd8;

    // scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_INT  = 2'd1;
    localparam logic [1:0] MODE_NAME = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // one result token
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        logic               trunc;
        logic [LINE_W-1:0]  line;
        logic               last;
    } tok_t;

    // tokens produced by one accepted item
    typedef struct packed {
        tok_t       tok0;
        tok_t       tok1;
        logic [1:0] count;
    } scan_out_t;

endpackage

// ===== design/aet_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_scan
// lexer state and per-character token decode, up to two tokens per item
// ----------------------------------------------------------------------------
module aet_scan #(
    parameter int NAME_MAX   = aet_pkg::NAME_MAX_DEFAULT,
    parameter int VALUE_BITS = aet_pkg::VALUE_BITS_DEFAULT,
    parameter int LINE_BITS  = aet_pkg::LINE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         character,
    input  logic               end_of_input,
    output aet_pkg::scan_out_t result
);
    import aet_pkg::*;

    localparam int SUM_W = VALUE_BITS + 4;
    localparam logic [SUM_W-1:0] MAXV = SUM_W'({VALUE_BITS{1'b1}});

    logic [1:0]            mode_reg, mode_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [CHARS_W-1:0]    name_reg, name_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic                  long_reg, long_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;

    logic                  is_digit, is_name, is_space;
    logic [SUM_W-1:0]      sum;
    logic [62:0]           acc_wide;
    logic                  pend_valid, sec_valid;
    tok_t                  pend_tok, sec_tok;

    assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_name  = ((character >= CH_LA) && (character <= CH_LZ))
                   || ((character >= CH_UA) && (character <= CH_UZ))
                   || (character == CH_UNDER);
    assign is_space = (character == CH_SPACE) || (character == CH_TAB)
                   || (character == CH_NL) || (character == CH_VT)
                   || (character == CH_FF) || (character == CH_CR);

    // acc * 10 + digit, wide enough to see an overflow
    assign sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
               + SUM_W'(character[3:0]);

    assign acc_wide = 63'(acc_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        name_next  = name_reg;
        cnt_next   = cnt_reg;
        long_next  = long_reg;
        line_next  = line_reg;
        pend_valid = 1'b0;
        sec_valid  = 1'b0;
        pend_tok   = '0;
        sec_tok    = '0;
        result     = '0;

        if (accept && !end_of_input && (character == CH_NL) && !(&line_reg)) begin
            line_next = line_reg + 1'b1;
        end

        // pending literal or identifier, used when it is closed
        if (mode_reg == MODE_INT) begin
            pend_tok.kind  = TK_INT;
            pend_tok.value = acc_wide[VALUE_W-1:0];
            pend_tok.ovf   = ovf_reg;
        end else begin
            pend_tok.kind  = TK_NAME;
            pend_tok.chars = name_reg;
            pend_tok.len   = cnt_reg;
            pend_tok.trunc = long_reg;
        end
        pend_tok.line = LINE_W'(line_next);
        sec_tok.line  = LINE_W'(line_next);

        if (accept) begin
            if (end_of_input) begin
                pend_valid   = (mode_reg == MODE_INT) || (mode_reg == MODE_NAME);
                sec_valid    = 1'b1;
                sec_tok.kind = TK_EOF;
                mode_next    = MODE_IDLE;
            end else if ((mode_reg == MODE_INT) && is_digit) begin
                if (sum > MAXV) begin
                    acc_next = {VALUE_BITS{1'b1}};
                    ovf_next = 1'b1;
                end else begin
                    acc_next = sum[VALUE_BITS-1:0];
                end
            end else if ((mode_reg == MODE_NAME) && is_name) begin
                if (cnt_reg < LEN_W'(NAME_MAX)) begin
                    for (int i = 0; i < NAME_SHOWN; i++) begin
                        if (cnt_reg == LEN_W'(i)) begin
                            name_next[8*i +: 8] = character;
                        end
                    end
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    long_next = 1'b1;
                end
            end else begin
                pend_valid = (mode_reg == MODE_INT) || (mode_reg == MODE_NAME);
                mode_next  = MODE_IDLE;
                if ((character == CH_NUL) || is_space) begin
                    sec_valid = 1'b0;
                end else if (character == CH_SEMI) begin
                    sec_valid    = 1'b1;
                    sec_tok.kind = TK_SEMI;
                end else if (character == CH_PLUS) begin
                    sec_valid    = 1'b1;
                    sec_tok.kind = TK_PLUS;
                end else if (character == CH_MINUS) begin
                    sec_valid    = 1'b1;
                    sec_tok.kind = TK_MINUS;
                end else if (character == CH_SLASH) begin
                    sec_valid    = 1'b1;
                    sec_tok.kind = TK_SLASH;
                end else if (character == CH_STAR) begin
                    sec_valid    = 1'b1;
                    sec_tok.kind = TK_STAR;
                end else if (is_digit) begin
                    mode_next = MODE_INT;
                    acc_next  = VALUE_BITS'(character[3:0]);
                    ovf_next  = 1'b0;
                end else if (is_name) begin
                    mode_next = MODE_NAME;
                    name_next = CHARS_W'(character);
                    cnt_next  = LEN_W'(1);
                    long_next = 1'b0;
                end else begin
                    sec_valid     = 1'b1;
                    sec_tok.kind  = TK_ERR;
                    sec_tok.chars = CHARS_W'(character);
                end
            end
        end

        // pack into slot order, last flag on the final token of the item
        if (pend_valid) begin
            result.tok0 = pend_tok;
            result.tok1 = sec_tok;
            result.tok0.last = !sec_valid;
            result.tok1.last = 1'b1;
        end else begin
            result.tok0 = sec_tok;
            result.tok0.last = 1'b1;
        end
        result.count = {1'b0, pend_valid} + {1'b0, sec_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            name_reg <= '0;
            cnt_reg  <= '0;
            long_reg <= 1'b0;
            line_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            name_reg <= name_next;
            cnt_reg  <= cnt_next;
            long_reg <= long_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== design/arith_expression_tokenizer_core.sv =====
`timescale 1ns / 1ps
// queue: a token is registered into the result queue when its item is accepted
// throughput: one item per cycle while m_tready is high; an item that closes a
//   literal or identifier and also yields its own token puts two tokens in the
//   two-entry result queue, which holds s_tready low until the first is taken
// reset: asynchronous, clears scan mode, accumulators, line count and queue
// ----------------------------------------------------------------------------
// arith_expression_tokenizer_core
// character-at-a-time lexer for integer expressions with a token output queue
// ----------------------------------------------------------------------------
module arith_expression_tokenizer_core #(
    parameter int NAME_MAX   = aet_pkg::NAME_MAX_DEFAULT,
    parameter int VALUE_BITS = aet_pkg::VALUE_BITS_DEFAULT,
    parameter int LINE_BITS  = aet_pkg::LINE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] character
    input  logic         s_tuser,   // [0] end_of_input
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // [30:0] literal_value, [31] value_overflow, [95:32] name_chars,
    // [100:96] name_length, [101] name_truncated, [117:102] line_number,
    // [119:118] zero
    output logic [119:0] m_tdata,
    output logic [3:0]   m_tuser,   // [3:0] token_kind
    output logic         m_tlast    // last token caused by the item
);
    import aet_pkg::*;

    scan_out_t  scan;
    logic       accept;
    logic       pop;

    // two-entry result queue, slot 0 is the head
    tok_t       q0_reg, q0_next;
    tok_t       q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_kept;
    tok_t       kept0;
    tok_t       kept1;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    // room for two tokens after this cycle's pop
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign accept   = s_tvalid && s_tready;

    aet_scan #(
        .NAME_MAX   (NAME_MAX),
        .VALUE_BITS (VALUE_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .character    (s_tdata),
        .end_of_input (s_tuser),
        .result       (scan)
    );

    always_comb
    begin
        // drop the head if it is taken this cycle
        if (pop) begin
            kept0    = q1_reg;
            kept1    = q1_reg;
            cnt_kept = cnt_reg - 2'd1;
        end else begin
            kept0    = q0_reg;
            kept1    = q1_reg;
            cnt_kept = cnt_reg;
        end

        // append new tokens behind what remains
        case (cnt_kept)
            2'd0:
            begin
                q0_next = scan.tok0;
                q1_next = scan.tok1;
            end
            2'd1:
            begin
                q0_next = kept0;
                q1_next = scan.tok0;
            end
            default:
            begin
                q0_next = kept0;
                q1_next = kept1;
            end
        endcase

        cnt_next = cnt_kept + scan.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // token payload needs no reset
    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tdata = {2'b00, q0_reg.line, q0_reg.trunc, q0_reg.len,
                      q0_reg.chars, q0_reg.ovf, q0_reg.value};
    assign m_tuser = q0_reg.kind;
    assign m_tlast = q0_reg.last;

endmodule
